>>> design/tpsc_pkg.sv
// ----------------------------------------------------------------------------
// tpsc_pkg: shared types and constants of the tiered position speed controller
// Operation and register codes, configuration bundle, tier decision and the
// percentage to PWM compare scaling.
// ----------------------------------------------------------------------------
package tpsc_pkg;

  localparam int POS_W     = 16;
  localparam int BAND_W    = 15;
  localparam int PCT_W     = 7;
  localparam int DUTY_W    = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 15;

  localparam logic [BAND_W-1:0] STARTUP_RADIUS = BAND_W'(50);
  localparam logic [BAND_W-1:0] MID_LIMIT      = BAND_W'(30);
  localparam logic [PCT_W-1:0]  PCT_FULL       = PCT_W'(100);
  localparam logic [BAND_W-1:0] MAG_MAX        = {BAND_W{1'b1}};

  // 512/100 as 20972/4096, exact floor for every percentage below 100
  localparam int DUTY_RECIP_W = 15;
  localparam int DUTY_SHIFT   = 12;
  localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP = DUTY_RECIP_W'(20972);

  typedef enum logic [1:0] {
    OP_SET_MEAS = 2'd0,
    OP_SET_TGT  = 2'd1,
    OP_SET_BOTH = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_BAND     = 4'd0,
    REG_NEAR_BAND     = 4'd1,
    REG_FAR_BAND      = 4'd2,
    REG_NEAR_SPEED    = 4'd3,
    REG_STARTUP_SPEED = 4'd4,
    REG_MID_SPEED     = 4'd5,
    REG_CRUISE_SPEED  = 4'd6,
    REG_FAR_SPEED     = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [BAND_W-1:0] stop_band;
    logic [BAND_W-1:0] near_band;
    logic [BAND_W-1:0] far_band;
    logic [PCT_W-1:0]  near_speed;
    logic [PCT_W-1:0]  startup_speed;
    logic [PCT_W-1:0]  mid_speed;
    logic [PCT_W-1:0]  cruise_speed;
    logic [PCT_W-1:0]  far_speed;
  } cfg_regs_t;

  typedef struct packed {
    logic             stop;
    logic             reverse;
    logic [PCT_W-1:0] pct;
  } tier_dec_t;

  // saturating magnitude of a 16-bit two's complement value
  function automatic logic [BAND_W-1:0] mag16(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] neg;
    neg = POS_W'(~v + POS_W'(1));
    if (v == {1'b1, {(POS_W-1){1'b0}}}) begin
      return MAG_MAX;
    end else if (v[POS_W-1]) begin
      return neg[BAND_W-1:0];
    end else begin
      return v[BAND_W-1:0];
    end
  endfunction

  // floor(512 * pct / 100) for pct below 100
  function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_W-1:0] pct);
    logic [PCT_W+DUTY_RECIP_W-1:0] prod;
    logic [PCT_W+DUTY_RECIP_W-1:0] shifted;
    prod    = (PCT_W+DUTY_RECIP_W)'(pct) * (PCT_W+DUTY_RECIP_W)'(DUTY_RECIP);
    shifted = prod >> DUTY_SHIFT;
    return shifted[DUTY_W-1:0];
  endfunction

endpackage

>>> design/tpsc_tier.sv
// ----------------------------------------------------------------------------
// tpsc_tier: position update and speed tier selection
// Applies the operation to the positions, forms the wrapping error, and picks
// the stop flag, direction and speed percentage.
// ----------------------------------------------------------------------------
module tpsc_tier
  import tpsc_pkg::*;
(
  input  logic [1:0]       op,
  input  logic [POS_W-1:0] pos,
  input  logic [POS_W-1:0] meas,
  input  logic [POS_W-1:0] tgt,
  input  logic [POS_W-1:0] rest,
  input  cfg_regs_t        cfg,
  output logic [POS_W-1:0] meas_nxt,
  output logic [POS_W-1:0] tgt_nxt,
  output tier_dec_t        dec
);

  logic [POS_W-1:0]  err;
  logic [BAND_W-1:0] abserr;
  logic [BAND_W-1:0] restdist;

  always_comb begin
    meas_nxt = meas;
    tgt_nxt  = tgt;
    case (op)
      OP_SET_MEAS: meas_nxt = pos;
      OP_SET_TGT:  tgt_nxt  = pos;
      default: begin
        // set both, also taken by the unused code
        meas_nxt = pos;
        tgt_nxt  = pos;
      end
    endcase
  end

  assign err      = POS_W'(tgt_nxt - meas_nxt);
  assign abserr   = mag16(err);
  assign restdist = mag16(POS_W'(meas_nxt - rest));

  always_comb begin
    dec.stop    = 1'b0;
    dec.reverse = err[POS_W-1];
    dec.pct     = '0;
    if (abserr < cfg.stop_band) begin
      dec.stop    = 1'b1;
      dec.reverse = 1'b0;
    end else if (abserr < cfg.near_band) begin
      dec.pct = cfg.near_speed;
    end else if (restdist < STARTUP_RADIUS) begin
      dec.pct = cfg.startup_speed;
    end else if (abserr < MID_LIMIT) begin
      dec.pct = cfg.mid_speed;
    end else if (abserr < cfg.far_band) begin
      dec.pct = cfg.cruise_speed;
    end else begin
      dec.pct = cfg.far_speed;
    end
  end

endmodule

>>> design/tiered_position_speed_controller.sv
// ----------------------------------------------------------------------------
// tiered_position_speed_controller: one crane axis position to PWM controller
// Tracks measured and target position, chooses a speed tier and drives the
// forward and reverse H-bridge compare values.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_operation, in_position
//  out     | output    | out_valid / out_ready | out_forward_duty, out_reverse_duty
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  an item is held in the input register, then its result is loaded
//  into the output register: one item per cycle sustained unless the output
//  stalls; the position update and tier choice is one combinational pass
//  a stalled output holds both stages; in_ready drops only when both are full
//  cfg_ready is always high; synchronous active-low reset restores the
//  register defaults and clears positions and compare values
// ----------------------------------------------------------------------------
module tiered_position_speed_controller
  import tpsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic signed [POS_W-1:0] in_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_W-1:0]    out_forward_duty,
  output logic [DUTY_W-1:0]    out_reverse_duty,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_regs_t         cfg_r;
  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic              out_valid_r;
  logic [DUTY_W-1:0] fwd_r, rev_r;
  logic [DUTY_W-1:0] fwd_nxt, rev_nxt;
  logic [POS_W-1:0]  meas_r, tgt_r, rest_r;
  logic [POS_W-1:0]  meas_nxt, tgt_nxt;
  tier_dec_t         dec;
  logic              adv;
  logic              in_acc;
  logic [DUTY_W-1:0] duty;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_band     <= BAND_W'(3);
      cfg_r.near_band     <= BAND_W'(10);
      cfg_r.far_band      <= BAND_W'(32767);
      cfg_r.near_speed    <= PCT_W'(10);
      cfg_r.startup_speed <= PCT_W'(20);
      cfg_r.mid_speed     <= PCT_W'(20);
      cfg_r.cruise_speed  <= PCT_W'(50);
      cfg_r.far_speed     <= PCT_W'(50);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STOP_BAND:     cfg_r.stop_band     <= cfg_data[BAND_W-1:0];
        REG_NEAR_BAND:     cfg_r.near_band     <= cfg_data[BAND_W-1:0];
        REG_FAR_BAND:      cfg_r.far_band      <= cfg_data[BAND_W-1:0];
        REG_NEAR_SPEED:    cfg_r.near_speed    <= cfg_data[PCT_W-1:0];
        REG_STARTUP_SPEED: cfg_r.startup_speed <= cfg_data[PCT_W-1:0];
        REG_MID_SPEED:     cfg_r.mid_speed     <= cfg_data[PCT_W-1:0];
        REG_CRUISE_SPEED:  cfg_r.cruise_speed  <= cfg_data[PCT_W-1:0];
        REG_FAR_SPEED:     cfg_r.far_speed     <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_operation;
      s1_pos_r <= in_position;
    end
  end

  tpsc_tier u_tier (
    .op       (s1_op_r),
    .pos      (s1_pos_r),
    .meas     (meas_r),
    .tgt      (tgt_r),
    .rest     (rest_r),
    .cfg      (cfg_r),
    .meas_nxt (meas_nxt),
    .tgt_nxt  (tgt_nxt),
    .dec      (dec)
  );

  assign duty = pct_to_duty(dec.pct);

  always_comb begin
    fwd_nxt = fwd_r;
    rev_nxt = rev_r;
    if (dec.stop || dec.pct == '0) begin
      fwd_nxt = '0;
      rev_nxt = '0;
    end else if (dec.pct < PCT_FULL) begin
      // out-of-range percentage keeps the compare values
      fwd_nxt = dec.reverse ? '0 : duty;
      rev_nxt = dec.reverse ? duty : '0;
    end
  end

  // axis state and result register, the compare values double as the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r      <= '0;
      tgt_r       <= '0;
      rest_r      <= '0;
      fwd_r       <= '0;
      rev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        meas_r <= meas_nxt;
        tgt_r  <= tgt_nxt;
        fwd_r  <= fwd_nxt;
        rev_r  <= rev_nxt;
        if (dec.stop) begin
          rest_r <= meas_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_forward_duty = fwd_r;
  assign out_reverse_duty = rev_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_forward_duty == '0 || out_reverse_duty == '0))
    else $error("both bridge sides driven");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd_r <= DUTY_W'(506)) && (rev_r <= DUTY_W'(506)))
    else $error("compare value beyond 99 percent");

  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("item advanced without a result");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with free output slot");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && dec.stop) |=> (fwd_r == '0 && rev_r == '0 && rest_r == meas_r))
    else $error("stop tier left motor running");

endmodule
